FILE: hdl/lppb_pkg.sv
// shared types, codes and register defaults for the long-press power button controller
`default_nettype none
package lppb_pkg;

	localparam int HOLD_W   = 20;
	localparam int BLINK_W  = 16;
	localparam int ADDR_W   = 5;
	localparam int DATA_W   = 32;

	localparam logic [HOLD_W-1:0]  HOLD_MAX   = '1;
	localparam logic [BLINK_W-1:0] TOGGLE_MAX = '1;

	// register defaults
	localparam logic [HOLD_W-1:0]  HALT_HOLD_RST     = HOLD_W'(2000);
	localparam logic [HOLD_W-1:0]  BOOT_HOLD_RST     = HOLD_W'(10000);
	localparam logic [HOLD_W-1:0]  RESTORE_HOLD_RST  = HOLD_W'(15000);
	localparam logic [HOLD_W-1:0]  IGNORE_HOLD_RST   = HOLD_W'(20000);
	localparam logic [BLINK_W-1:0] HALT_BLINK_RST    = BLINK_W'(1000);
	localparam logic [BLINK_W-1:0] BOOT_BLINK_RST    = BLINK_W'(500);
	localparam logic [BLINK_W-1:0] RESTORE_BLINK_RST = BLINK_W'(250);

	// register indexes (byte address / 4)
	typedef enum logic [2:0] {
		REG_HALT_HOLD     = 3'd0,
		REG_BOOT_HOLD     = 3'd1,
		REG_RESTORE_HOLD  = 3'd2,
		REG_IGNORE_HOLD   = 3'd3,
		REG_HALT_BLINK    = 3'd4,
		REG_BOOT_BLINK    = 3'd5,
		REG_RESTORE_BLINK = 3'd6,
		REG_UNUSED        = 3'd7
	} reg_idx_t;

	typedef enum logic [1:0] {
		REQ_TICK     = 2'd0,
		REQ_BUTTON   = 2'd1,
		REQ_ACTIVATE = 2'd2,
		REQ_NONE     = 2'd3
	} req_type_t;

	typedef enum logic [1:0] {
		BM_STANDBY  = 2'd0,
		BM_ACTIVE   = 2'd1,
		BM_CHANGING = 2'd2
	} board_mode_t;

	typedef enum logic [1:0] {
		PM_ACTIVE  = 2'd0,
		PM_HALT    = 2'd1,
		PM_BOOT    = 2'd2,
		PM_RESTORE = 2'd3
	} press_mode_t;

	typedef enum logic [1:0] {
		ACT_NONE    = 2'd0,
		ACT_HALT    = 2'd1,
		ACT_REBOOT  = 2'd2,
		ACT_RESTORE = 2'd3
	} action_t;

	// configuration seen by the core
	typedef struct packed {
		logic [HOLD_W-1:0]  halt_hold;
		logic [HOLD_W-1:0]  boot_hold;
		logic [HOLD_W-1:0]  restore_hold;
		logic [HOLD_W-1:0]  ignore_hold;
		logic [BLINK_W-1:0] halt_blink;
		logic [BLINK_W-1:0] boot_blink;
		logic [BLINK_W-1:0] restore_blink;
	} cfg_t;

endpackage
`default_nettype wire

FILE: hdl/lppb_regs.sv
// apb configuration registers for the long-press power button controller
`default_nettype none
module lppb_regs
	import lppb_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [ADDR_W-1:0] paddr,
	input  wire logic [DATA_W-1:0] pwdata,
	output logic      [DATA_W-1:0] prdata,
	output logic                   pready,
	output cfg_t                   cfg
);

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign pready = 1'b1;
	assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
	assign wr_en  = psel & penable & pwrite & pready;
	assign cfg    = cfg_q;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.halt_hold     <= HALT_HOLD_RST;
			cfg_q.boot_hold     <= BOOT_HOLD_RST;
			cfg_q.restore_hold  <= RESTORE_HOLD_RST;
			cfg_q.ignore_hold   <= IGNORE_HOLD_RST;
			cfg_q.halt_blink    <= HALT_BLINK_RST;
			cfg_q.boot_blink    <= BOOT_BLINK_RST;
			cfg_q.restore_blink <= RESTORE_BLINK_RST;
		end else if (wr_en) begin
			unique case (idx)
				REG_HALT_HOLD:     cfg_q.halt_hold     <= pwdata[HOLD_W-1:0];
				REG_BOOT_HOLD:     cfg_q.boot_hold     <= pwdata[HOLD_W-1:0];
				REG_RESTORE_HOLD:  cfg_q.restore_hold  <= pwdata[HOLD_W-1:0];
				REG_IGNORE_HOLD:   cfg_q.ignore_hold   <= pwdata[HOLD_W-1:0];
				REG_HALT_BLINK:    cfg_q.halt_blink    <= pwdata[BLINK_W-1:0];
				REG_BOOT_BLINK:    cfg_q.boot_blink    <= pwdata[BLINK_W-1:0];
				REG_RESTORE_BLINK: cfg_q.restore_blink <= pwdata[BLINK_W-1:0];
				default: ;
			endcase
		end
	end

	// read mux
	always_comb begin
		prdata = '0;
		unique case (idx)
			REG_HALT_HOLD:     prdata = DATA_W'(cfg_q.halt_hold);
			REG_BOOT_HOLD:     prdata = DATA_W'(cfg_q.boot_hold);
			REG_RESTORE_HOLD:  prdata = DATA_W'(cfg_q.restore_hold);
			REG_IGNORE_HOLD:   prdata = DATA_W'(cfg_q.ignore_hold);
			REG_HALT_BLINK:    prdata = DATA_W'(cfg_q.halt_blink);
			REG_BOOT_BLINK:    prdata = DATA_W'(cfg_q.boot_blink);
			REG_RESTORE_BLINK: prdata = DATA_W'(cfg_q.restore_blink);
			default:           prdata = '0;
		endcase
	end

endmodule
`default_nettype wire

FILE: hdl/lppb_core.sv
// input stage, controller state update and result register
`default_nettype none
module lppb_core
	import lppb_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire cfg_t       cfg,
	input  wire logic       s_tvalid,
	output logic            s_tready,
	input  wire logic [7:0] s_tdata,   // [0] button_pressed
	input  wire logic [1:0] s_tuser,   // [1:0] req_type
	output logic            m_tvalid,
	input  wire logic       m_tready,
	output logic      [7:0] m_tdata    // [0] led_on, [2:1] board_mode, [4:3] press_mode,
	                                   // [6:5] action
);

	// input stage
	logic      valid_s1;
	req_type_t req_s1;
	logic      pressed_s1;

	// controller state
	board_mode_t        board_q;
	press_mode_t        press_q;
	logic               holding_q;
	logic [HOLD_W-1:0]  hold_q;
	logic               led_q;
	logic [BLINK_W-1:0] toggle_q;
	logic               blink_en_q;

	// result register
	logic    out_valid_q;
	logic    out_led_q;
	action_t out_act_q;

	// next state
	board_mode_t        board_d;
	press_mode_t        press_d;
	logic               holding_d;
	logic [HOLD_W-1:0]  hold_d;
	logic               led_d;
	logic [BLINK_W-1:0] toggle_d;
	logic               blink_en_d;
	action_t            act_d;

	logic advance;

	assign advance  = valid_s1 & (~out_valid_q | m_tready);
	assign s_tready = ~valid_s1 | advance;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = {1'b0, out_act_q, press_q, board_q, out_led_q};

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			req_s1     <= req_type_t'(s_tuser);
			pressed_s1 <= s_tdata[0];
		end
	end

	// per-item state update
	always_comb begin
		logic [BLINK_W-1:0] period;
		board_d    = board_q;
		press_d    = press_q;
		holding_d  = holding_q;
		hold_d     = hold_q;
		led_d      = led_q;
		toggle_d   = toggle_q;
		blink_en_d = blink_en_q;
		act_d      = ACT_NONE;
		period     = cfg.restore_blink;
		unique case (req_s1)
			REQ_TICK: begin
				if (toggle_q != TOGGLE_MAX)
					toggle_d = toggle_q + 1'b1;
				if (holding_q && hold_q != HOLD_MAX)
					hold_d = hold_q + 1'b1;
				if (blink_en_q) begin
					// pick press mode from hold time, ignore threshold first
					if (holding_q) begin
						if (hold_d >= cfg.ignore_hold)
							hold_d = '0;
						else if (hold_d >= cfg.restore_hold)
							press_d = PM_RESTORE;
						else if (hold_d >= cfg.boot_hold)
							press_d = PM_BOOT;
						else if (hold_d >= cfg.halt_hold)
							press_d = PM_HALT;
						else
							press_d = PM_ACTIVE;
					end
					// led update
					case (press_d)
						PM_HALT: period = cfg.halt_blink;
						PM_BOOT: period = cfg.boot_blink;
						default: period = cfg.restore_blink;
					endcase
					if (press_d == PM_ACTIVE) begin
						led_d    = 1'b1;
						toggle_d = '0;
					end else if (toggle_d >= period) begin
						led_d    = ~led_q;
						toggle_d = '0;
					end
				end
			end
			REQ_BUTTON: begin
				if (board_q == BM_ACTIVE) begin
					if (pressed_s1) begin
						holding_d  = 1'b1;
						hold_d     = '0;
						blink_en_d = 1'b1;
					end else begin
						// release starts the state change; from active or restore press mode the board stays active
						holding_d = 1'b0;
						hold_d    = '0;
						board_d   = BM_CHANGING;
						case (press_q)
							PM_HALT:    act_d = ACT_HALT;
							PM_BOOT:    act_d = ACT_REBOOT;
							PM_RESTORE: act_d = ACT_RESTORE;
							default:    act_d = ACT_NONE;
						endcase
						if (press_q == PM_ACTIVE || press_q == PM_RESTORE) begin
							led_d      = 1'b1;
							board_d    = BM_ACTIVE;
							press_d    = PM_ACTIVE;
							blink_en_d = 1'b0;
						end
					end
				end else if (board_q == BM_STANDBY) begin
					board_d = BM_CHANGING;
				end
			end
			REQ_ACTIVATE: begin
				led_d      = 1'b1;
				board_d    = BM_ACTIVE;
				press_d    = PM_ACTIVE;
				blink_en_d = 1'b0;
			end
			default: ;
		endcase
	end

	// state and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			board_q     <= BM_STANDBY;
			press_q     <= PM_BOOT;
			holding_q   <= 1'b0;
			hold_q      <= '0;
			led_q       <= 1'b0;
			toggle_q    <= '0;
			blink_en_q  <= 1'b1;
			out_valid_q <= 1'b0;
			out_led_q   <= 1'b0;
			out_act_q   <= ACT_NONE;
		end else begin
			if (advance) begin
				board_q    <= board_d;
				press_q    <= press_d;
				holding_q  <= holding_d;
				hold_q     <= hold_d;
				led_q      <= led_d;
				toggle_q   <= toggle_d;
				blink_en_q <= blink_en_d;
				out_led_q  <= led_d;
				out_act_q  <= act_d;
			end
			if (advance)
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;
		end
	end

endmodule
`default_nettype wire

FILE: hdl/long_press_power_button_controller_top.sv
// Long-press power button controller, top level.
// An input transfer passes the input register, then the state update into the
// result register, before its result transfer.
// Throughput: one item per cycle unless m_tready stalls; the state update is
// one pass of compares and counter increments from input to result register.
// Reset: arst_n clears control state asynchronously; registers take their defaults.
`default_nettype none
module long_press_power_button_controller_top
	import lppb_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	// configuration
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [ADDR_W-1:0] paddr,
	input  wire logic [DATA_W-1:0] pwdata,
	output logic      [DATA_W-1:0] prdata,
	output logic                   pready,
	// requests
	input  wire logic              s_tvalid,
	output logic                   s_tready,
	input  wire logic [7:0]        s_tdata,   // [0] button_pressed
	input  wire logic [1:0]        s_tuser,   // [1:0] req_type
	// results
	output logic                   m_tvalid,
	input  wire logic              m_tready,
	output logic      [7:0]        m_tdata    // [0] led_on, [2:1] board_mode,
	                                          // [4:3] press_mode, [6:5] action
);

	cfg_t cfg;

	lppb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	lppb_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule
`default_nettype wire

FILE: tb/sv/tb.sv
// self-checking testbench for the long-press power button controller top level
`timescale 1ns / 1ps
module tb;
	import lppb_pkg::*;

	// watchdog limit for the whole run, with margin for idling and stalls
	localparam int CYCLE_LIMIT = 400000;
	localparam int SHOWN_MAX   = 10;
	localparam int LONG_STALL  = 80;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic              pready;
	logic              s_tvalid;
	logic              s_tready;
	logic [7:0]        s_tdata;   // [0] button_pressed
	logic [1:0]        s_tuser;   // [1:0] req_type
	logic              m_tvalid;
	logic              m_tready;
	logic [7:0]        m_tdata;   // [0] led_on, [2:1] board_mode, [4:3] press_mode, [6:5] action

	long_press_power_button_controller_top dut (.*);

	always #6 clk = ~clk;

	// status bytes still owed by the block, oldest first
	logic [7:0] status_due [$];
	logic [7:0] want_status;
	int         results_seen = 0;
	int         mismatch_count = 0;
	int         sent_count = 0;
	int         cycle_count = 0;
	bit         no_idle = 1'b0;
	bit         long_stall_done = 1'b0;
	bit         paused_once = 1'b0;

	// own copy of the settings and the controller state
	logic [HOLD_W-1:0]  cfg_q [0:6];
	board_mode_t        board_q;
	press_mode_t        press_q;
	logic               holding_q;
	logic               led_q;
	logic               blink_q;
	logic [HOLD_W-1:0]  hold_q;
	logic [BLINK_W-1:0] toggle_q;

	// directed opening sequence; typed is -1 where the tracked status is used
	typedef struct {
		req_type_t req;
		logic      pressed;
		int        typed;
	} step_row_t;

	step_row_t script [27] = '{
		'{REQ_NONE,     1'b0, 'h10},  // unused request right after reset
		'{REQ_NONE,     1'b1, 'h10},
		'{REQ_TICK,     1'b0, -1},    // blinking in standby
		'{REQ_TICK,     1'b0, -1},
		'{REQ_BUTTON,   1'b1, -1},    // any level change in standby
		'{REQ_BUTTON,   1'b0, -1},    // ignored while changing
		'{REQ_ACTIVATE, 1'b0, 'h03},
		'{REQ_BUTTON,   1'b0, -1},    // release with no hold reactivates
		'{REQ_BUTTON,   1'b1, -1},
		'{REQ_TICK,     1'b0, -1},
		'{REQ_TICK,     1'b0, -1},
		'{REQ_TICK,     1'b0, -1},
		'{REQ_TICK,     1'b0, -1},
		'{REQ_TICK,     1'b0, -1},
		'{REQ_BUTTON,   1'b0, -1},    // release in reboot
		'{REQ_ACTIVATE, 1'b0, 'h03},
		'{REQ_TICK,     1'b0, -1},    // blinking stopped after activation
		'{REQ_BUTTON,   1'b1, -1},
		'{REQ_TICK,     1'b0, -1},
		'{REQ_TICK,     1'b0, -1},
		'{REQ_TICK,     1'b0, -1},
		'{REQ_TICK,     1'b0, -1},
		'{REQ_TICK,     1'b0, -1},
		'{REQ_TICK,     1'b0, -1},
		'{REQ_TICK,     1'b0, -1},
		'{REQ_TICK,     1'b0, -1},    // ignore threshold restarts the count
		'{REQ_BUTTON,   1'b0, -1}     // release in restore
	};

	function automatic void reset_tracker();
		cfg_q[REG_HALT_HOLD]     = HALT_HOLD_RST;
		cfg_q[REG_BOOT_HOLD]     = BOOT_HOLD_RST;
		cfg_q[REG_RESTORE_HOLD]  = RESTORE_HOLD_RST;
		cfg_q[REG_IGNORE_HOLD]   = IGNORE_HOLD_RST;
		cfg_q[REG_HALT_BLINK]    = HOLD_W'(HALT_BLINK_RST);
		cfg_q[REG_BOOT_BLINK]    = HOLD_W'(BOOT_BLINK_RST);
		cfg_q[REG_RESTORE_BLINK] = HOLD_W'(RESTORE_BLINK_RST);
		board_q   = BM_STANDBY;
		press_q   = PM_BOOT;
		holding_q = 1'b0;
		hold_q    = '0;
		led_q     = 1'b0;
		toggle_q  = '0;
		blink_q   = 1'b1;
	endfunction

	function automatic void wake_board();
		led_q   = 1'b1;
		board_q = BM_ACTIVE;
		press_q = PM_ACTIVE;
		blink_q = 1'b0;
	endfunction

	// one millisecond tick: counters, press mode from hold time, then the led
	function automatic void count_tick();
		logic [BLINK_W-1:0] period;
		if (toggle_q != TOGGLE_MAX)
			toggle_q = toggle_q + 1'b1;
		if (holding_q && hold_q != HOLD_MAX)
			hold_q = hold_q + 1'b1;
		if (blink_q) begin
			if (holding_q) begin
				if (hold_q >= cfg_q[REG_IGNORE_HOLD])
					hold_q = '0;
				else if (hold_q >= cfg_q[REG_RESTORE_HOLD])
					press_q = PM_RESTORE;
				else if (hold_q >= cfg_q[REG_BOOT_HOLD])
					press_q = PM_BOOT;
				else if (hold_q >= cfg_q[REG_HALT_HOLD])
					press_q = PM_HALT;
				else
					press_q = PM_ACTIVE;
			end
			if (press_q == PM_ACTIVE) begin
				led_q    = 1'b1;
				toggle_q = '0;
			end else begin
				case (press_q)
					PM_HALT: period = cfg_q[REG_HALT_BLINK][BLINK_W-1:0];
					PM_BOOT: period = cfg_q[REG_BOOT_BLINK][BLINK_W-1:0];
					default: period = cfg_q[REG_RESTORE_BLINK][BLINK_W-1:0];
				endcase
				if (toggle_q >= period) begin
					led_q    = ~led_q;
					toggle_q = '0;
				end
			end
		end
	endfunction

	// advance the tracked controller by one request and return its status byte
	function automatic logic [7:0] apply_request(req_type_t req, logic pressed);
		action_t act;
		act = ACT_NONE;
		case (req)
			REQ_TICK: count_tick();
			REQ_BUTTON: begin
				if (board_q == BM_ACTIVE) begin
					if (pressed) begin
						holding_q = 1'b1;
						hold_q    = '0;
						blink_q   = 1'b1;
					end else begin
						holding_q = 1'b0;
						hold_q    = '0;
						board_q   = BM_CHANGING;
						case (press_q)
							PM_HALT: act = ACT_HALT;
							PM_BOOT: act = ACT_REBOOT;
							PM_RESTORE: begin
								act = ACT_RESTORE;
								wake_board();
							end
							default: wake_board();
						endcase
					end
				end else if (board_q == BM_STANDBY) begin
					board_q = BM_CHANGING;
				end
			end
			REQ_ACTIVATE: wake_board();
			default: ;
		endcase
		return {1'b0, act, press_q, board_q, led_q};
	endfunction

	function automatic cfg_t pack_settings(int hh, int bh, int rh, int ih, int hb, int bb,
			int rb);
		cfg_t c;
		c.halt_hold     = HOLD_W'(hh);
		c.boot_hold     = HOLD_W'(bh);
		c.restore_hold  = HOLD_W'(rh);
		c.ignore_hold   = HOLD_W'(ih);
		c.halt_blink    = BLINK_W'(hb);
		c.boot_blink    = BLINK_W'(bb);
		c.restore_blink = BLINK_W'(rb);
		return c;
	endfunction

	// mostly back to back, sometimes short gaps, rarely long ones
	function automatic int pick_gap();
		int r;
		if (no_idle)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic void flag_mismatch(string field, logic [7:0] want, logic [7:0] got);
		if (mismatch_count < SHOWN_MAX)
			$display("%0t ns: %s differs, expected status %02h, got %02h",
				$time, field, want, got);
		mismatch_count++;
	endfunction

	// apb write: setup cycle, then access until pready
	task automatic write_reg(reg_idx_t idx, logic [DATA_W-1:0] value);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ADDR_W'({idx, 2'b00});
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		cfg_q[idx] = (idx >= REG_HALT_BLINK) ? HOLD_W'(value[BLINK_W-1:0])
			: value[HOLD_W-1:0];
	endtask

	task automatic program_regs(cfg_t c);
		write_reg(REG_HALT_HOLD, DATA_W'(c.halt_hold));
		write_reg(REG_BOOT_HOLD, DATA_W'(c.boot_hold));
		write_reg(REG_RESTORE_HOLD, DATA_W'(c.restore_hold));
		write_reg(REG_IGNORE_HOLD, DATA_W'(c.ignore_hold));
		write_reg(REG_HALT_BLINK, DATA_W'(c.halt_blink));
		write_reg(REG_BOOT_BLINK, DATA_W'(c.boot_blink));
		write_reg(REG_RESTORE_BLINK, DATA_W'(c.restore_blink));
	endtask

	// offer one request and wait for its transfer
	task automatic push_request(req_type_t req, logic pressed, int typed);
		int gap;
		logic [7:0] predicted;
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= req;
		s_tdata  <= {7'd0, pressed};
		do @(posedge clk); while (!s_tready);
		predicted = apply_request(req, pressed);
		status_due.push_back(typed < 0 ? predicted : typed[7:0]);
		sent_count++;
	endtask

	task automatic push_noise();
		push_request(req_type_t'($urandom_range(0, 3)), 1'($urandom_range(0, 1)), -1);
	endtask

	// activate (most of the time), press, hold for some ticks, release; some are broken on purpose
	task automatic send_hold(int max_ticks);
		int r;
		int ticks;
		int cut;
		r = $urandom_range(0, 99);
		if (r < 80)
			push_request(REQ_ACTIVATE, 1'b0, -1);
		push_request(REQ_BUTTON, 1'b1, -1);
		ticks = $urandom_range(0, max_ticks);
		cut = (r >= 85) ? $urandom_range(0, ticks) : -1;
		for (int i = 0; i < ticks; i++) begin
			if (i == cut)
				push_noise();
			push_request(REQ_TICK, 1'b0, -1);
		end
		push_request(REQ_BUTTON, 1'b0, -1);
		repeat ($urandom_range(0, 3)) push_request(REQ_TICK, 1'b0, -1);
	endtask

	// stop offering until every owed status has arrived, then idle a little
	task automatic settle(int extra);
		s_tvalid <= 1'b0;
		do @(posedge clk); while (status_due.size() != 0);
		repeat (extra) @(posedge clk);
	endtask

	task automatic run_phase(cfg_t c, int items);
		int stop_at;
		int cap;
		program_regs(c);
		cap = (c.ignore_hold < 40) ? int'(c.ignore_hold) + 3 : 40;
		stop_at = sent_count + items;
		while (sent_count < stop_at) begin
			if ($urandom_range(0, 99) < 75)
				send_hold(cap);
			else
				repeat ($urandom_range(1, 4)) push_noise();
			if (!paused_once && sent_count >= 550) begin
				paused_once = 1'b1;
				settle(0);
			end
		end
		settle(4);
	endtask

	// result side: random stalls, one long hold-off once traffic is flowing
	initial begin : receiver
		int stall_len;
		m_tready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (!long_stall_done && results_seen >= 300) begin
				long_stall_done = 1'b1;
				stall_len = LONG_STALL;
			end else begin
				stall_len = pick_gap();
			end
			if (stall_len > 0) begin
				m_tready <= 1'b0;
				repeat (stall_len) @(posedge clk);
			end
			m_tready <= 1'b1;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
	end

	// compare each result transfer with the oldest owed status
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			results_seen++;
			if (status_due.size() == 0) begin
				flag_mismatch("unexpected transfer", 8'h00, m_tdata);
			end else begin
				want_status = status_due.pop_front();
				if (m_tdata[0] !== want_status[0])
					flag_mismatch("led_on", want_status, m_tdata);
				if (m_tdata[2:1] !== want_status[2:1])
					flag_mismatch("board_mode", want_status, m_tdata);
				if (m_tdata[4:3] !== want_status[4:3])
					flag_mismatch("press_mode", want_status, m_tdata);
				if (m_tdata[6:5] !== want_status[6:5])
					flag_mismatch("action", want_status, m_tdata);
				if (m_tdata[7] !== 1'b0)
					flag_mismatch("padding", want_status, m_tdata);
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin
		arst_n   <= 1'b0;
		psel     <= 1'b0;
		penable  <= 1'b0;
		pwrite   <= 1'b0;
		paddr    <= '0;
		pwdata   <= '0;
		s_tvalid <= 1'b0;
		s_tdata  <= '0;
		s_tuser  <= REQ_TICK;
		reset_tracker();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// directed part with short thresholds so every press mode is reached
		program_regs(pack_settings(2, 4, 6, 8, 1, 2, 3));
		foreach (script[i])
			push_request(script[i].req, script[i].pressed, script[i].typed);
		settle(4);

		// random part over ordered, minimal, misordered, maximal and mixed settings
		run_phase(pack_settings(2, 5, 9, 14, 2, 3, 1), 180);
		no_idle = 1'b1;
		run_phase(pack_settings(1, 1, 1, 1, 1, 1, 1), 140);
		no_idle = 1'b0;
		run_phase(pack_settings(7, 3, 12, 5, 4, 2, 6), 180);
		run_phase(pack_settings(20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF,
			16'hFFFF, 16'hFFFF, 16'hFFFF), 60);
		run_phase(pack_settings(1, 3, 4, 20'hFFFFF, 16'hFFFF, 1, 2), 180);
		settle(8);

		if (mismatch_count == 0 && status_due.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

FILE: filelist.f
hdl/lppb_pkg.sv
hdl/lppb_regs.sv
hdl/lppb_core.sv
hdl/long_press_power_button_controller_top.sv
tb/sv/tb.sv
